// ----- hw/rtl/sfa_pkg.sv -----
// stratified fold assigner package: sizes, transaction kind codes, register indexes
// and the sample memory entry type; no dependencies
`default_nettype none

package sfa_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int NUM_CLASSES = 256;
    localparam int MAX_FOLDS   = 16;

    localparam int KIND_W    = 2;
    localparam int LABEL_W   = 8;
    localparam int INDEX_W   = 12;
    localparam int FOLD_W    = 5;
    localparam int CFG_W     = 13;
    localparam int COUNT_W   = $clog2(MAX_SAMPLES) + 1;
    localparam int SAMPLE_AW = $clog2(MAX_SAMPLES);
    localparam int CLASS_AW  = $clog2(NUM_CLASSES);
    localparam int FD_W      = $clog2(MAX_FOLDS);
    localparam int PROD_W    = 2 * COUNT_W;
    localparam int ACC_W     = COUNT_W + FOLD_W;

    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    localparam logic REG_FOLD_COUNT     = 1'b0;
    localparam logic REG_DROP_THRESHOLD = 1'b1;

    localparam logic [FOLD_W-1:0] FOLD_COUNT_RESET = 5'd5;
    localparam logic [CFG_W-1:0]  DROP_RESET       = 13'd0;
    localparam logic [FOLD_W-1:0] FOLD_NONE        = 5'h1F;

    typedef struct packed {
        logic [CLASS_AW-1:0]  class_id;
        logic [SAMPLE_AW-1:0] position;
    } sample_entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/stratified_fold_assigner_core.sv -----
// stratified fold assigner top level: class counters, sample memory and the
// iterative fold search sequencer; depends on sfa_pkg
`default_nettype none

// Stratified k-fold split without shuffling. A load transaction stores the label's
// class and in-class position and bumps the class counter; a clear transaction zeroes
// all class counters at once through per-class valid bits and restarts the sample
// count. A read transaction returns the fold of one sample, or -1 when the index is
// not loaded or the class is dropped. A load is ignored once the data set is full.
// The fold search runs one fold per cycle, through at most the fold count (clamped
// to 16), using a single shared adder and comparator. The block takes no new
// transaction until the current one is finished and its result sits in the output
// register; a waiting result holds the sequencer only until the output register
// frees.
module stratified_fold_assigner_core (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_wr_en,
    input  wire  [0:0]                          cfg_index,
    input  wire  [sfa_pkg::CFG_W-1:0]           cfg_data,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire  [sfa_pkg::KIND_W-1:0]          kind,
    input  wire  [sfa_pkg::LABEL_W-1:0]         label,
    input  wire  [sfa_pkg::INDEX_W-1:0]         sample_index,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic signed [sfa_pkg::FOLD_W-1:0]   fold,
    output logic [sfa_pkg::INDEX_W-1:0]         echo_index
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_RSMP = 3'd2;
    localparam logic [2:0] S_RCLS = 3'd3;
    localparam logic [2:0] S_DROP = 3'd4;
    localparam logic [2:0] S_FOLD = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    localparam int COUNT_W   = sfa_pkg::COUNT_W;
    localparam int SAMPLE_AW = sfa_pkg::SAMPLE_AW;
    localparam int CLASS_AW  = sfa_pkg::CLASS_AW;
    localparam int FOLD_W    = sfa_pkg::FOLD_W;
    localparam int FD_W      = sfa_pkg::FD_W;
    localparam int PROD_W    = sfa_pkg::PROD_W;
    localparam int ACC_W     = sfa_pkg::ACC_W;
    localparam int CFG_W     = sfa_pkg::CFG_W;

    // configuration
    logic [FOLD_W-1:0] fold_count_reg;
    logic [CFG_W-1:0]  drop_threshold_reg;
    logic [FOLD_W-1:0] eff_folds;

    // control
    logic [2:0]         state_reg, state_next;
    logic [COUNT_W-1:0] loaded_reg, loaded_next;
    logic [sfa_pkg::NUM_CLASSES-1:0] class_valid_reg, class_valid_next;
    logic               out_valid_reg, out_valid_next;

    // datapath
    logic [CLASS_AW-1:0]          label_reg, label_next;
    logic [sfa_pkg::INDEX_W-1:0]  index_reg, index_next;
    logic [SAMPLE_AW-1:0]         pos_reg, pos_next;
    logic [COUNT_W-1:0]           size_reg, size_next;
    logic [PROD_W-1:0]            prod_reg, prod_next;
    logic [ACC_W-1:0]             target_reg, target_next;
    logic [ACC_W-1:0]             acc_reg, acc_next;
    logic [FD_W-1:0]              fd_reg, fd_next;
    logic [FOLD_W-1:0]            fold_reg, fold_next;
    logic [FOLD_W-1:0]            res_fold_reg, res_fold_next;
    logic [sfa_pkg::INDEX_W-1:0]  res_index_reg, res_index_next;

    // memories
    logic [COUNT_W-1:0]           class_mem [sfa_pkg::NUM_CLASSES];
    sfa_pkg::sample_entry_t       sample_mem [sfa_pkg::MAX_SAMPLES];
    logic [CLASS_AW-1:0]          class_rd_addr;
    logic [COUNT_W-1:0]           class_rd_q;
    logic                         class_vld_q;
    logic                         class_we;
    logic [COUNT_W-1:0]           class_wdata;
    sfa_pkg::sample_entry_t       sample_rd_q;
    logic                         sample_we;
    sfa_pkg::sample_entry_t       sample_wdata;
    logic [COUNT_W-1:0]           cur_size;

    logic in_fire;
    logic out_free;

    assign in_fire  = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign fold       = $signed(res_fold_reg);
    assign echo_index = res_index_reg;

    always_comb
    begin
        if (fold_count_reg == '0)
        begin
            eff_folds = FOLD_W'(1);
        end
        else if (fold_count_reg > FOLD_W'(sfa_pkg::MAX_FOLDS))
        begin
            eff_folds = FOLD_W'(sfa_pkg::MAX_FOLDS);
        end
        else
        begin
            eff_folds = fold_count_reg;
        end
    end

    assign cur_size      = class_vld_q ? class_rd_q : '0;
    assign class_rd_addr = (state_reg == S_RSMP) ? sample_rd_q.class_id : label;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_count_reg     <= sfa_pkg::FOLD_COUNT_RESET;
            drop_threshold_reg <= sfa_pkg::DROP_RESET;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == sfa_pkg::REG_FOLD_COUNT)
            begin
                fold_count_reg <= cfg_data[FOLD_W-1:0];
            end
            else if (cfg_index == sfa_pkg::REG_DROP_THRESHOLD)
            begin
                drop_threshold_reg <= cfg_data;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        loaded_next      = loaded_reg;
        class_valid_next = class_valid_reg;
        out_valid_next   = out_valid_reg;
        label_next       = label_reg;
        index_next       = index_reg;
        pos_next         = pos_reg;
        size_next        = size_reg;
        prod_next        = prod_reg;
        target_next      = target_reg;
        acc_next         = acc_reg;
        fd_next          = fd_reg;
        fold_next        = fold_reg;
        res_fold_next    = res_fold_reg;
        res_index_next   = res_index_reg;
        class_we         = 1'b0;
        class_wdata      = cur_size + COUNT_W'(1);
        sample_we        = 1'b0;
        sample_wdata.class_id = label_reg;
        sample_wdata.position = cur_size[SAMPLE_AW-1:0];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    label_next = label;
                    index_next = sample_index;
                    case (kind)
                        sfa_pkg::KIND_CLEAR:
                        begin
                            class_valid_next = '0;
                            loaded_next      = '0;
                        end
                        sfa_pkg::KIND_LOAD:
                        begin
                            if (loaded_reg < COUNT_W'(sfa_pkg::MAX_SAMPLES))
                            begin
                                state_next = S_LOAD;
                            end
                        end
                        sfa_pkg::KIND_READ:
                        begin
                            if ({1'b0, sample_index} >= loaded_reg)
                            begin
                                fold_next  = sfa_pkg::FOLD_NONE;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                state_next = S_RSMP;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                class_we  = 1'b1;
                sample_we = 1'b1;
                class_valid_next[label_reg] = 1'b1;
                loaded_next = loaded_reg + COUNT_W'(1);
                state_next  = S_IDLE;
            end
            S_RSMP:
            begin
                pos_next   = sample_rd_q.position;
                state_next = S_RCLS;
            end
            S_RCLS:
            begin
                size_next   = cur_size;
                prod_next   = PROD_W'(cur_size) * PROD_W'(drop_threshold_reg);
                target_next = ACC_W'({1'b0, pos_reg} + COUNT_W'(1)) * ACC_W'(eff_folds);
                state_next  = S_DROP;
            end
            S_DROP:
            begin
                if (prod_reg < PROD_W'(loaded_reg))
                begin
                    fold_next  = sfa_pkg::FOLD_NONE;
                    state_next = S_OUT;
                end
                else
                begin
                    acc_next   = ACC_W'(size_reg);
                    fd_next    = '0;
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                // acc holds (fd+1)*size; fold found when (pos+1)*folds <= acc or fd is the last fold
                if ((target_reg <= acc_reg) || ({1'b0, fd_reg} == eff_folds - FOLD_W'(1)))
                begin
                    fold_next  = {1'b0, fd_reg};
                    state_next = S_OUT;
                end
                else
                begin
                    fd_next  = fd_reg + FD_W'(1);
                    acc_next = acc_reg + ACC_W'(size_reg);
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    res_fold_next  = fold_reg;
                    res_index_next = index_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            loaded_reg      <= '0;
            class_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            loaded_reg      <= loaded_next;
            class_valid_reg <= class_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        label_reg     <= label_next;
        index_reg     <= index_next;
        pos_reg       <= pos_next;
        size_reg      <= size_next;
        prod_reg      <= prod_next;
        target_reg    <= target_next;
        acc_reg       <= acc_next;
        fd_reg        <= fd_next;
        fold_reg      <= fold_next;
        res_fold_reg  <= res_fold_next;
        res_index_reg <= res_index_next;
    end

    // class counter memory
    always_ff @(posedge clk)
    begin
        if (class_we)
        begin
            class_mem[label_reg] <= class_wdata;
        end
        class_rd_q  <= class_mem[class_rd_addr];
        class_vld_q <= class_valid_reg[class_rd_addr];
    end

    // sample memory
    always_ff @(posedge clk)
    begin
        if (sample_we)
        begin
            sample_mem[loaded_reg[SAMPLE_AW-1:0]] <= sample_wdata;
        end
        sample_rd_q <= sample_mem[sample_index[SAMPLE_AW-1:0]];
    end

`ifndef SYNTHESIS
    a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg <= COUNT_W'(sfa_pkg::MAX_SAMPLES))
        else $error("sample count above capacity");

    a_clear_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && kind == sfa_pkg::KIND_CLEAR) |=> (loaded_reg == '0 && class_valid_reg == '0))
        else $error("clear did not restart the data set");

    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_fold_reg == sfa_pkg::FOLD_NONE || res_fold_reg < eff_folds))
        else $error("result fold outside the fold count");

    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FOLD) |-> ({1'b0, fd_reg} < eff_folds))
        else $error("fold search ran past the last fold");

    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |=> (loaded_reg == $past(loaded_reg) + COUNT_W'(1)))
        else $error("load did not advance the sample count");
`endif

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// testbench for stratified_fold_assigner_core: directed, fold setting sweep, large data set
// and random tests; a local fold predictor checks every result; depends on sfa_pkg
`default_nettype none

module testbench;

    localparam int MAX_SAMPLES = sfa_pkg::MAX_SAMPLES;
    localparam int NUM_CLASSES = sfa_pkg::NUM_CLASSES;
    localparam int MAX_FOLDS   = sfa_pkg::MAX_FOLDS;
    localparam int KIND_W      = sfa_pkg::KIND_W;
    localparam int LABEL_W     = sfa_pkg::LABEL_W;
    localparam int INDEX_W     = sfa_pkg::INDEX_W;
    localparam int FOLD_W      = sfa_pkg::FOLD_W;
    localparam int CFG_W       = sfa_pkg::CFG_W;

    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 30;
    localparam int RANDOM_ITEMS = 1000;
    localparam int LARGE_LOADS  = 300;
    localparam int MAX_REPORTS  = 10;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [FOLD_W-1:0]  fold;
        logic [INDEX_W-1:0] index;
    } fold_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [0:0]                 cfg_index;
    logic [CFG_W-1:0]           cfg_data;
    logic                       in_valid;
    wire                        in_ready;
    logic [KIND_W-1:0]          kind;
    logic [LABEL_W-1:0]         label;
    logic [INDEX_W-1:0]         sample_index;
    wire                        out_valid;
    logic                       out_ready;
    wire signed [FOLD_W-1:0]    fold;
    wire [INDEX_W-1:0]          echo_index;

    // predictor state
    int unsigned                class_count [NUM_CLASSES];
    logic [LABEL_W-1:0]         sample_cls [MAX_SAMPLES];
    int unsigned                sample_pos [MAX_SAMPLES];
    int unsigned                loaded_count;
    logic [FOLD_W-1:0]          cur_folds;
    logic [CFG_W-1:0]           cur_drop;

    fold_result_t               pending_folds [$];
    int                         mismatches = 0;
    int                         idle_cycles = 0;
    int                         items_sent = 0;
    bit                         calm = 1'b0;

    stratified_fold_assigner_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .label        (label),
        .sample_index (sample_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .fold         (fold),
        .echo_index   (echo_index)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [FOLD_W-1:0] fold_for_sample(int unsigned idx);
        int unsigned size;
        int unsigned pos;
        int unsigned folds;
        int unsigned lo;
        int unsigned hi;
        if (idx >= loaded_count)
            return sfa_pkg::FOLD_NONE;
        size = class_count[sample_cls[idx]];
        pos  = sample_pos[idx];
        if (size * cur_drop < loaded_count)
            return sfa_pkg::FOLD_NONE;
        if (cur_folds == 0)
            folds = 1;
        else if (cur_folds > MAX_FOLDS)
            folds = MAX_FOLDS;
        else
            folds = cur_folds;
        for (int unsigned fd = 0; fd < folds; fd++)
        begin
            lo = fd * size / folds;
            hi = (fd == folds - 1) ? size : (fd + 1) * size / folds;
            if (pos >= lo && pos < hi)
                return FOLD_W'(fd);
        end
        return FOLD_W'(folds - 1);
    endfunction

    task automatic track_item(input logic [KIND_W-1:0] k, input logic [LABEL_W-1:0] l,
                              input logic [INDEX_W-1:0] i);
        case (k)
            sfa_pkg::KIND_CLEAR:
            begin
                foreach (class_count[c])
                    class_count[c] = 0;
                loaded_count = 0;
            end
            sfa_pkg::KIND_LOAD:
            begin
                if (loaded_count < MAX_SAMPLES)
                begin
                    sample_cls[loaded_count] = l;
                    sample_pos[loaded_count] = class_count[l];
                    class_count[l]++;
                    loaded_count++;
                end
            end
            sfa_pkg::KIND_READ:
                pending_folds.push_back('{fold: fold_for_sample(i), index: i});
            default:
                ;
        endcase
    endtask

    task automatic log_failure(input string msg);
        if (mismatches < MAX_REPORTS)
            $display("%t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic send_item(input logic [KIND_W-1:0] k, input logic [LABEL_W-1:0] l,
                             input logic [INDEX_W-1:0] i);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        label        <= l;
        sample_index <= i;
        do @(posedge clk); while (!in_ready);
        track_item(k, l, i);
        if (k != KIND_UNUSED)
            items_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_folds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [FOLD_W-1:0] fc, input logic [CFG_W-1:0] dt);
        cfg_wr_en <= 1'b1;
        cfg_index <= sfa_pkg::REG_FOLD_COUNT;
        cfg_data  <= CFG_W'(fc);
        @(posedge clk);
        cur_folds = fc;
        cfg_index <= sfa_pkg::REG_DROP_THRESHOLD;
        cfg_data  <= dt;
        @(posedge clk);
        cur_drop = dt;
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [INDEX_W-1:0] pick_index();
        if (loaded_count != 0 && $urandom_range(0, 4) != 0)
            return INDEX_W'($urandom_range(0, loaded_count - 1));
        return INDEX_W'($urandom_range(0, MAX_SAMPLES - 1));
    endfunction

    // clear, then loads drawn from a small label pool, then reads; some noise in between
    task automatic load_and_read(input int n_loads, input int pool_size, input int n_reads);
        logic [LABEL_W-1:0] pool [8];
        foreach (pool[p])
            pool[p] = LABEL_W'($urandom_range(0, NUM_CLASSES - 1));
        send_item(sfa_pkg::KIND_CLEAR, LABEL_W'($urandom), INDEX_W'($urandom));
        for (int n = 0; n < n_loads; n++)
        begin
            send_item(sfa_pkg::KIND_LOAD, pool[$urandom_range(0, pool_size - 1)],
                      INDEX_W'($urandom));
            if ($urandom_range(0, 7) == 0)
                send_item(sfa_pkg::KIND_READ, LABEL_W'($urandom), pick_index());
            if ($urandom_range(0, 15) == 0)
                send_item(KIND_UNUSED, LABEL_W'($urandom), INDEX_W'($urandom));
        end
        for (int n = 0; n < n_reads; n++)
        begin
            send_item(sfa_pkg::KIND_READ, LABEL_W'($urandom), pick_index());
            if ($urandom_range(0, 15) == 0)
                send_item(KIND_UNUSED, LABEL_W'($urandom), INDEX_W'($urandom));
        end
    endtask

    task automatic test_directed();
        calm = 1'b0;
        send_item(sfa_pkg::KIND_READ, 8'h00, 12'd0);
        send_item(sfa_pkg::KIND_READ, 8'hFF, 12'hFFF);
        send_item(sfa_pkg::KIND_LOAD, 8'h00, 12'd0);
        send_item(sfa_pkg::KIND_LOAD, 8'hFF, 12'hFFF);
        for (int n = 0; n < 4; n++)
            send_item(sfa_pkg::KIND_LOAD, 8'h00, 12'd0);
        send_item(sfa_pkg::KIND_LOAD, 8'h80, 12'd0);
        for (int n = 0; n < 8; n++)
            send_item(sfa_pkg::KIND_READ, 8'h00, INDEX_W'(n));
        send_item(sfa_pkg::KIND_READ, 8'h00, 12'hFFF);
        send_item(KIND_UNUSED, 8'hFF, 12'hFFF);
        send_item(sfa_pkg::KIND_CLEAR, 8'hFF, 12'hFFF);
        send_item(sfa_pkg::KIND_READ, 8'h00, 12'd0);
        send_item(sfa_pkg::KIND_LOAD, 8'hAA, 12'd0);
        send_item(sfa_pkg::KIND_READ, 8'h00, 12'd0);
    endtask

    task automatic test_fold_settings();
        logic [FOLD_W-1:0] fc_list [11] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2,
                                            5'd3, 5'd7, 5'd16, 5'd4, 5'd5};
        logic [CFG_W-1:0]  dt_list [11] = '{13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd4096,
                                            13'd8191, 13'd1, 13'd3, 13'd2, 13'd0};
        for (int s = 0; s < 11; s++)
        begin
            wait_idle();
            calm = (s % 4 == 3);
            set_config(fc_list[s], dt_list[s]);
            load_and_read($urandom_range(20, 48), 4, 12);
        end
    endtask

    task automatic test_large_set();
        wait_idle();
        calm = 1'b0;
        set_config(5'd16, CFG_W'($urandom_range(2, 4)));
        load_and_read(LARGE_LOADS, $urandom_range(1, 4), 30);
        send_item(sfa_pkg::KIND_READ, 8'h00, 12'hFFF);
        send_item(sfa_pkg::KIND_READ, 8'h00, 12'd0);
    endtask

    task automatic test_random();
        int target;
        logic [FOLD_W-1:0] fc;
        logic [CFG_W-1:0]  dt;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            wait_idle();
            calm = ($urandom_range(0, 3) == 0);
            fc = ($urandom_range(0, 7) == 0) ? FOLD_W'($urandom) : FOLD_W'($urandom_range(1, 16));
            case ($urandom_range(0, 3))
                0: dt = '0;
                1: dt = CFG_W'($urandom);
                default: dt = CFG_W'($urandom_range(1, 8));
            endcase
            set_config(fc, dt);
            load_and_read($urandom_range(1, 60), $urandom_range(1, 8), $urandom_range(4, 30));
            // broken sequences: random kinds on top of the loaded set
            repeat ($urandom_range(0, 6))
                send_item(KIND_W'($urandom), LABEL_W'($urandom), pick_index());
        end
    endtask

    always @(posedge clk)
    begin : check_results
        fold_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_folds.size() == 0)
                log_failure($sformatf("unexpected transaction fold=%0d index=%0d",
                                      fold, echo_index));
            else
            begin
                want = pending_folds.pop_front();
                if (fold !== want.fold || echo_index !== want.index)
                    log_failure($sformatf("expected fold=%0d index=%0d, got fold=%0d index=%0d",
                                          $signed(want.fold), want.index, fold, echo_index));
            end
        end
    end

    initial
    begin : drive_out_ready
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("stratified_fold_assigner_core test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n        <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= sfa_pkg::REG_FOLD_COUNT;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        kind         <= sfa_pkg::KIND_CLEAR;
        label        <= '0;
        sample_index <= '0;
        cur_folds    = sfa_pkg::FOLD_COUNT_RESET;
        cur_drop     = sfa_pkg::DROP_RESET;
        foreach (class_count[c])
            class_count[c] = 0;
        loaded_count = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fold_settings();
        test_large_set();
        test_random();
        wait_idle();

        if (mismatches == 0)
            $display("stratified_fold_assigner_core test passed");
        else
            $display("stratified_fold_assigner_core test failed");
        $finish;
    end

endmodule

`default_nettype wire
